// ----- rtl/core/swarq_pkg.sv -----
`timescale 1ns / 1ps

package swarq_pkg;

  localparam int TmrW = 8;   // per-frame timer width
  localparam int IdxW = 8;   // frame_index field width
  localparam int BaseW = 9;  // window_base / frame_number width

  // action codes
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_ACK  = 2'd1;
  localparam logic [1:0] ACT_NAK  = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_WINDOW_SIZE   = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd1;
  localparam logic [1:0] CFG_FRAME_COUNT   = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } st_e;

  // write controls for the frame store
  typedef struct packed {
    logic ack_we;
    logic ack_bit;
    logic tmr_we;
  } store_wr_t;

endpackage

// ----- rtl/core/swarq_store.sv -----
`timescale 1ns / 1ps

// Per-frame ack flags and timers, one write and one registered read port.
module swarq_store import swarq_pkg::*; #(
  parameter int Depth = 256,
  parameter int AddrW = 8
) (
  input  logic            clk_i,
  input  store_wr_t       wr_ctl_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [TmrW-1:0] tmr_wdata_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic            ack_rd_o,
  output logic [TmrW-1:0] tmr_rd_o
);

  logic            ack_mem [Depth];
  logic [TmrW-1:0] tmr_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_ctl_i.ack_we) begin
      ack_mem[wr_addr_i] <= wr_ctl_i.ack_bit;
    end
    ack_rd_o <= ack_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_ctl_i.tmr_we) begin
      tmr_mem[wr_addr_i] <= tmr_wdata_i;
    end
    tmr_rd_o <= tmr_mem[rd_addr_i];
  end

endmodule

// ----- rtl/core/swarq_sendq.sv -----
`timescale 1ns / 1ps

// List of frames requested during one tick, read back in push order.
module swarq_sendq import swarq_pkg::*; #(
  parameter int Depth = 8
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    clr_i,
  input  logic                                    push_i,
  input  logic [IdxW-1:0]                         push_data_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr_i,
  output logic [$clog2(Depth+1)-1:0]              count_o,
  output logic [IdxW-1:0]                         rd_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [IdxW-1:0] mem [Depth];
  logic [CntW-1:0] wr_cnt_q, wr_cnt_d;

  always_comb begin
    wr_cnt_d = wr_cnt_q;
    if (clr_i) begin
      wr_cnt_d = '0;
    end else if (push_i) begin
      wr_cnt_d = wr_cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_cnt_q <= '0;
    end else begin
      wr_cnt_q <= wr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_cnt_q[PtrW-1:0]] <= push_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

  assign count_o = wr_cnt_q;

endmodule

// ----- rtl/core/sliding_window_arq_sender.sv -----
`timescale 1ns / 1ps

// Transmit control of a selective-repeat ARQ sender with one timer per frame.
// After reset the block clears its frame store, one frame per cycle, over all
// MAX_FRAMES frames; busy stays high during that pass (config writes are taken
// as always). A beat is taken when start is high and busy is low. ACK and NAK
// beats update the store in that same cycle and produce no result. A tick scans
// the window from the base, one frame per cycle through a single compare /
// decrement unit fed by the registered store read, then plays out the send
// requests one per cycle, or a single beat with send_valid_o low if there are
// none. A tick scans at most max(window size, 1) frames, never over MAX_WINDOW.
// Each result sits on the output ports for exactly one cycle, flagged by
// result_valid_o; the receiver cannot stall, so it must take every beat.
// Results are registered from the emit cycles, so the last result of a tick shows in
// the first cycle busy is low again.
module sliding_window_arq_sender import swarq_pkg::*; #(
  parameter int MAX_FRAMES = 256,
  parameter int MAX_WINDOW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // command channel
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       action_i,
  input  logic [BaseW-1:0] frame_number_i,
  // config write port
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [BaseW-1:0] cfg_data_i,
  // results
  output logic             result_valid_o,
  output logic             send_valid_o,
  output logic [IdxW-1:0]  frame_index_o,
  output logic             last_of_tick_o,
  output logic [BaseW-1:0] window_base_o,
  output logic             transfer_done_o
);

  localparam int AddrW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CntW  = ($clog2(MAX_FRAMES + 1) > BaseW) ? $clog2(MAX_FRAMES + 1) : BaseW;
  localparam int PtrW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int QcW   = $clog2(MAX_WINDOW + 1);
  localparam logic [CntW-1:0] MaxFramesC = CntW'(MAX_FRAMES);
  localparam logic [CntW-1:0] MaxWinC    = CntW'(MAX_WINDOW);
  localparam logic [CntW-1:0] LastClrC   = CntW'(MAX_FRAMES - 1);

  // config registers
  logic [3:0]       window_size_q;
  logic [TmrW-1:0]  timeout_q;
  logic [BaseW-1:0] frame_count_q;

  // sequencer state
  st_e             state_q, state_d;
  logic [CntW-1:0] clr_idx_q;
  logic [CntW-1:0] base_q;
  logic [CntW-1:0] end_q;
  logic [CntW-1:0] iss_idx_q;
  logic            ev_vld_q;
  logic [CntW-1:0] ev_idx_q;
  logic [CntW-1:0] target_q;
  logic            moving_q;
  logic [QcW-1:0]  em_k_q;

  // output stage
  logic             out_vld_q;
  logic             out_send_q;
  logic             out_last_q;
  logic [BaseW-1:0] out_base_q;
  logic             out_done_q;

  // effective config
  logic [CntW-1:0] cnt_ext, eff_cnt, win_ext, eff_win, scan_end;
  logic [CntW:0]   win_sum;
  logic [CntW-1:0] n_ext;

  // store interface
  store_wr_t       st_wr;
  logic [CntW-1:0] st_wr_idx;
  logic [TmrW-1:0] st_tmr_wdata;
  logic            ack_rd;
  logic [TmrW-1:0] tmr_rd;

  // shared evaluate unit
  logic            tmr_zero;
  logic [TmrW-1:0] tmr_next;

  // send list
  logic            q_clr, q_push;
  logic [QcW-1:0]  q_count;
  logic [IdxW-1:0] q_rd_data;

  logic            tick_go, iss_go, em_last;
  logic [QcW-1:0]  em_total;

  // ---------------------------------------------------------------------
  // Effective window bounds
  // ---------------------------------------------------------------------
  always_comb begin
    cnt_ext = CntW'(frame_count_q);
    eff_cnt = (cnt_ext > MaxFramesC) ? MaxFramesC : cnt_ext;
    win_ext = CntW'(window_size_q);
    if (win_ext == '0) begin
      eff_win = CntW'(1);
    end else if (win_ext > MaxWinC) begin
      eff_win = MaxWinC;
    end else begin
      eff_win = win_ext;
    end
    win_sum  = {1'b0, base_q} + {1'b0, eff_win};
    // base above count gives end below base: empty scan
    scan_end = (win_sum > {1'b0, eff_cnt}) ? eff_cnt : win_sum[CntW-1:0];
    n_ext    = CntW'(frame_number_i);
  end

  assign tick_go  = (state_q == ST_IDLE) && start && (action_i == ACT_TICK);
  assign iss_go   = (state_q == ST_SCAN) && (iss_idx_q < end_q);
  assign em_total = (q_count == '0) ? QcW'(1) : q_count;
  assign em_last  = (em_k_q == em_total - QcW'(1));

  // one step of the scan: reload on expiry, else count down
  assign tmr_zero = (tmr_rd == '0);
  assign tmr_next = tmr_zero ? timeout_q : tmr_rd - TmrW'(1);

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_idx_q == LastClrC) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (tick_go) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (!iss_go && !ev_vld_q) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (em_last) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs (store writes, send list)
  // ---------------------------------------------------------------------
  always_comb begin
    busy         = 1'b1;
    st_wr        = '0;
    st_wr_idx    = ev_idx_q;
    st_tmr_wdata = tmr_next;
    q_clr        = 1'b0;
    q_push       = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        st_wr        = '{ack_we: 1'b1, ack_bit: 1'b0, tmr_we: 1'b1};
        st_wr_idx    = clr_idx_q;
        st_tmr_wdata = '0;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          priority if (action_i == ACT_ACK) begin
            // ACK n acknowledges frame n-1
            if (n_ext != '0 && n_ext <= eff_cnt) begin
              st_wr.ack_we  = 1'b1;
              st_wr.ack_bit = 1'b1;
              st_wr_idx     = n_ext - CntW'(1);
            end
          end else if (action_i == ACT_NAK) begin
            if (n_ext < eff_cnt) begin
              st_wr.tmr_we = 1'b1;
              st_wr_idx    = n_ext;
              st_tmr_wdata = '0;
            end
          end else if (action_i == ACT_TICK) begin
            q_clr = 1'b1;
          end else begin
            q_clr = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (ev_vld_q && !ack_rd) begin
          st_wr.tmr_we = 1'b1;
          q_push       = tmr_zero;
        end
      end
      ST_EMIT: begin
        busy = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= 4'd4;
      timeout_q     <= TmrW'(3);
      frame_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW_SIZE:   window_size_q <= cfg_data_i[3:0];
        CFG_TIMEOUT_TICKS: timeout_q     <= cfg_data_i[TmrW-1:0];
        CFG_FRAME_COUNT:   frame_count_q <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_idx_q <= '0;
      base_q    <= '0;
      end_q     <= '0;
      iss_idx_q <= '0;
      ev_vld_q  <= 1'b0;
      ev_idx_q  <= '0;
      target_q  <= '0;
      moving_q  <= 1'b0;
      em_k_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ev_vld_q <= iss_go;
      ev_idx_q <= iss_idx_q;
      if (state_q == ST_CLEAR) clr_idx_q <= clr_idx_q + CntW'(1);

      if (tick_go) begin
        iss_idx_q <= base_q;
        end_q     <= scan_end;
        target_q  <= base_q;
        moving_q  <= 1'b1;
        em_k_q    <= '0;
      end
      if (iss_go) iss_idx_q <= iss_idx_q + CntW'(1);

      // base follows the first unacked frame while the run of acks holds
      if (state_q == ST_SCAN && ev_vld_q && moving_q) begin
        if (ack_rd) begin
          target_q <= ev_idx_q + CntW'(1);
        end else begin
          target_q <= ev_idx_q;
          moving_q <= 1'b0;
        end
      end
      if (state_q == ST_SCAN && state_d == ST_EMIT) base_q <= target_q;

      if (state_q == ST_EMIT) em_k_q <= em_k_q + QcW'(1);
      out_vld_q <= (state_q == ST_EMIT);
    end
  end

  // result payload, registered from the emit step (matches the list read)
  always_ff @(posedge clk_i) begin
    out_send_q <= (q_count != '0);
    out_last_q <= em_last;
    out_base_q <= base_q[BaseW-1:0];
    out_done_q <= (base_q >= eff_cnt);
  end

  // ---------------------------------------------------------------------
  // Storage
  // ---------------------------------------------------------------------
  swarq_store #(
    .Depth (MAX_FRAMES),
    .AddrW (AddrW)
  ) u_store (
    .clk_i       (clk_i),
    .wr_ctl_i    (st_wr),
    .wr_addr_i   (st_wr_idx[AddrW-1:0]),
    .tmr_wdata_i (st_tmr_wdata),
    .rd_addr_i   (iss_idx_q[AddrW-1:0]),
    .ack_rd_o    (ack_rd),
    .tmr_rd_o    (tmr_rd)
  );

  swarq_sendq #(
    .Depth (MAX_WINDOW)
  ) u_sendq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (q_clr),
    .push_i      (q_push),
    .push_data_i (ev_idx_q[IdxW-1:0]),
    .rd_addr_i   (em_k_q[PtrW-1:0]),
    .count_o     (q_count),
    .rd_data_o   (q_rd_data)
  );

  assign result_valid_o  = out_vld_q;
  assign send_valid_o    = out_send_q;
  assign frame_index_o   = out_send_q ? q_rd_data : '0;
  assign last_of_tick_o  = out_last_q;
  assign window_base_o   = out_base_q;
  assign transfer_done_o = out_done_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_tick_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && action_i == ACT_TICK) |=> busy)
    else $error("tick accepted but block not busy");

  a_no_rw_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && st_wr.tmr_we && iss_go) |-> (st_wr_idx != iss_idx_q))
    else $error("timer write hits the frame being read");

  a_sendq_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_count < QcW'(MAX_WINDOW)))
    else $error("send list overflow");

  a_one_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_of_tick_o) |=> !result_valid_o)
    else $error("result beat after last of tick");

endmodule
